// ----- src/esre_pkg.sv -----
`default_nettype none

package esre_pkg;

  // field widths
  localparam int NOW_W      = 48;
  localparam int TTG_W      = 32;
  localparam int BYTES_W    = 48;
  localparam int RATE_W     = 40;
  localparam int WEIGHT_W   = 17;
  localparam int INTERVAL_W = 32;

  localparam int RATE_FRAC_BITS = 16;
  localparam int TIME_W         = NOW_W + 1;
  localparam int AVG_W          = RATE_W + RATE_FRAC_BITS;

  // stream packing
  localparam int IN_DATA_W      = ((NOW_W + TTG_W + BYTES_W + 7) / 8) * 8;
  localparam int OUT_DATA_W     = ((RATE_W + 7) / 8) * 8;
  localparam int OUT_USER_W     = 2;
  localparam int USER_CLOSED_BIT = 0;
  localparam int USER_OOO_BIT    = 1;

  // configuration port
  localparam int CFG_DATA_W = RATE_W;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP  = 2'd2;

  localparam logic [WEIGHT_W-1:0]   WEIGHT_RST   = WEIGHT_W'(6554);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(200000);
  localparam logic [RATE_W-1:0]     STARTUP_RST  = RATE_W'(1000);

  localparam int Q16_BITS = 16;
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

  // bytes to bits per second with time in microseconds
  localparam int RATE_SCALE_INT = 8 * 1000000;
  localparam int RATE_SCALE_W   = $clog2(RATE_SCALE_INT + 1);
  localparam int MUL_B_W        = 24;
  localparam logic [MUL_B_W-1:0] RATE_SCALE = MUL_B_W'(RATE_SCALE_INT);

  // operand splits for the shared multiplier
  localparam int NB_LO_W   = BYTES_W / 2;
  localparam int RATE_LO_W = RATE_W / 2;
  localparam int AVG_LO_W  = AVG_W / 2;
  localparam int AVG_HI_W  = AVG_W - AVG_LO_W;
  localparam int MUL_A_W   = AVG_HI_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam int NUM_W     = BYTES_W + RATE_SCALE_W;
  localparam int BLEND_W   = AVG_W + WEIGHT_W;
  localparam int ACC_W     = ((BLEND_W > NUM_W) ? BLEND_W : NUM_W) + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_NUM_LO,
    ST_NUM_HI,
    ST_NUM_DRAIN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_RATE,
    ST_BL_RATE_LO,
    ST_BL_RATE_HI,
    ST_BL_AVG_LO,
    ST_BL_AVG_HI,
    ST_BL_DRAIN,
    ST_BL_COMMIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_NB_LO,
    MUL_NB_HI,
    MUL_RATE_LO,
    MUL_RATE_HI,
    MUL_AVG_LO,
    MUL_AVG_HI
  } mul_op_t;

  typedef struct packed {
    logic    capture;
    logic    eval;
    logic    first_load;
    mul_op_t mul_op;
    logic    acc_clr;
    logic    div_load;
    logic    div_step;
    logic    avg_from_rate;
    logic    avg_from_acc;
    logic    win_restart;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic ooo;
    logic close;
    logic avg_zero;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/esre_ctrl.sv -----
`default_nettype none

module esre_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  esre_pkg::dp_status_t  status,
  output esre_pkg::dp_cmd_t     cmd
);
  import esre_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.started && !status.ooo && status.close) state_next = ST_NUM_LO;
        else state_next = ST_DONE;
      end
      ST_NUM_LO:    state_next = ST_NUM_HI;
      ST_NUM_HI:    state_next = ST_NUM_DRAIN;
      ST_NUM_DRAIN: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (status.div_last) state_next = ST_RATE;
      end
      ST_RATE: begin
        if (status.avg_zero) state_next = ST_DONE;
        else state_next = ST_BL_RATE_LO;
      end
      ST_BL_RATE_LO: state_next = ST_BL_RATE_HI;
      ST_BL_RATE_HI: state_next = ST_BL_AVG_LO;
      ST_BL_AVG_LO:  state_next = ST_BL_AVG_HI;
      ST_BL_AVG_HI:  state_next = ST_BL_DRAIN;
      ST_BL_DRAIN:   state_next = ST_BL_COMMIT;
      ST_BL_COMMIT:  state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.eval       = 1'b1;
        cmd.first_load = !status.started;
      end
      ST_NUM_LO: begin
        cmd.mul_op  = MUL_NB_LO;
        cmd.acc_clr = 1'b1;
      end
      ST_NUM_HI:   cmd.mul_op   = MUL_NB_HI;
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV_RUN:  cmd.div_step = 1'b1;
      ST_RATE: begin
        cmd.avg_from_rate = status.avg_zero;
        cmd.win_restart   = status.avg_zero;
      end
      ST_BL_RATE_LO: begin
        cmd.mul_op  = MUL_RATE_LO;
        cmd.acc_clr = 1'b1;
      end
      ST_BL_RATE_HI: cmd.mul_op = MUL_RATE_HI;
      ST_BL_AVG_LO:  cmd.mul_op = MUL_AVG_LO;
      ST_BL_AVG_HI:  cmd.mul_op = MUL_AVG_HI;
      ST_BL_COMMIT: begin
        cmd.avg_from_acc = 1'b1;
        cmd.win_restart  = 1'b1;
      end
      ST_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/esre_dp.sv -----
`default_nettype none

module esre_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  esre_pkg::dp_cmd_t                  cmd,
  output esre_pkg::dp_status_t               status,
  input  logic [esre_pkg::NOW_W-1:0]         now_usec,
  input  logic [esre_pkg::TTG_W-1:0]         ttg_usec,
  input  logic [esre_pkg::BYTES_W-1:0]       bytes_total,
  input  logic [esre_pkg::WEIGHT_W-1:0]      weight_q16,
  input  logic [esre_pkg::INTERVAL_W-1:0]    interval_usec,
  input  logic [esre_pkg::RATE_W-1:0]        startup_rate_bps,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [esre_pkg::RATE_W-1:0]        avg_rate_bps,
  output logic                               window_closed,
  output logic                               out_of_order
);
  import esre_pkg::*;

  // captured event
  logic [TIME_W-1:0]  exp_q;
  logic [BYTES_W-1:0] bytes_q;

  // estimator state
  logic               started;
  logic [TIME_W-1:0]  wsu;
  logic [BYTES_W-1:0] wsb;
  logic [AVG_W-1:0]   avg;

  // window closing operands
  logic [BYTES_W-1:0] nb;
  logic [TIME_W-1:0]  elapsed;
  logic               flag_closed;
  logic               flag_ooo;

  // shared multiplier and accumulator
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  mul_op_t            prod_op;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_term;

  // restoring divider
  logic [NUM_W-1:0]     div_num;
  logic [TIME_W-1:0]    div_rem;
  logic [RATE_W-1:0]    div_q;
  logic                 div_ovf;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 ge;
  logic [TIME_W-1:0]    rem_next;

  logic [RATE_W-1:0]   rate;
  logic [WEIGHT_W-1:0] w;
  logic [WEIGHT_W-1:0] m;
  logic [TIME_W:0]     win_end;
  logic                ooo_c;
  logic                close_c;

  assign ooo_c   = bytes_q < wsb;
  assign win_end = (TIME_W + 1)'(wsu) + (TIME_W + 1)'(interval_usec);
  assign close_c = (TIME_W + 1)'(exp_q) > win_end;

  assign rate = div_ovf ? {RATE_W{1'b1}} : div_q;
  assign w    = (weight_q16 > ONE_Q16) ? ONE_Q16 : weight_q16;
  assign m    = ONE_Q16 - w;

  assign trial    = {div_rem, div_num[NUM_W-1]};
  assign ge       = trial >= {1'b0, elapsed};
  assign diff     = trial - {1'b0, elapsed};
  assign rem_next = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];

  always_comb begin
    status.started  = started;
    status.ooo      = ooo_c;
    status.close    = close_c;
    status.avg_zero = (avg == '0);
    status.div_last = (div_cnt == '0);
    status.out_free = !out_valid || out_ready;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_NB_LO: begin
        mul_a = MUL_A_W'(nb[NB_LO_W-1:0]);
        mul_b = RATE_SCALE;
      end
      MUL_NB_HI: begin
        mul_a = MUL_A_W'(nb[BYTES_W-1:NB_LO_W]);
        mul_b = RATE_SCALE;
      end
      MUL_RATE_LO: begin
        mul_a = MUL_A_W'(rate[RATE_LO_W-1:0]);
        mul_b = MUL_B_W'(w);
      end
      MUL_RATE_HI: begin
        mul_a = MUL_A_W'(rate[RATE_W-1:RATE_LO_W]);
        mul_b = MUL_B_W'(w);
      end
      MUL_AVG_LO: begin
        mul_a = MUL_A_W'(avg[AVG_LO_W-1:0]);
        mul_b = MUL_B_W'(m);
      end
      MUL_AVG_HI: begin
        mul_a = MUL_A_W'(avg[AVG_W-1:AVG_LO_W]);
        mul_b = MUL_B_W'(m);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // partial product placed by the op it was issued for
  always_comb begin
    case (prod_op)
      MUL_NB_LO:   acc_term = ACC_W'(prod);
      MUL_NB_HI:   acc_term = ACC_W'(prod) << NB_LO_W;
      MUL_RATE_LO: acc_term = ACC_W'(prod) << RATE_FRAC_BITS;
      MUL_RATE_HI: acc_term = ACC_W'(prod) << (RATE_FRAC_BITS + RATE_LO_W);
      MUL_AVG_LO:  acc_term = ACC_W'(prod);
      MUL_AVG_HI:  acc_term = ACC_W'(prod) << AVG_LO_W;
      default:     acc_term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      prod_op   <= MUL_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.first_load) started <= 1'b1;
      prod_op <= cmd.mul_op;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      exp_q   <= TIME_W'(now_usec) + TIME_W'(ttg_usec);
      bytes_q <= bytes_total;
    end

    if (cmd.eval) begin
      nb          <= bytes_q - wsb;
      elapsed     <= exp_q - wsu;
      flag_ooo    <= started && ooo_c;
      flag_closed <= started && !ooo_c && close_c;
    end

    if (cmd.first_load || cmd.win_restart) begin
      wsu <= exp_q;
      wsb <= bytes_q;
    end

    if (cmd.first_load) avg <= {startup_rate_bps, {RATE_FRAC_BITS{1'b0}}};
    else if (cmd.avg_from_rate) avg <= {rate, {RATE_FRAC_BITS{1'b0}}};
    else if (cmd.avg_from_acc) avg <= acc[Q16_BITS +: AVG_W];

    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.acc_clr) acc <= '0;
    else if (prod_op != MUL_NONE) acc <= acc + acc_term;

    if (cmd.div_load) begin
      div_num <= acc[NUM_W-1:0];
      div_rem <= '0;
      div_q   <= '0;
      div_ovf <= 1'b0;
      div_cnt <= DIV_CNT_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      div_num <= div_num << 1;
      div_rem <= rem_next;
      div_q   <= {div_q[RATE_W-2:0], ge};
      div_ovf <= div_ovf | div_q[RATE_W-1];
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end

    if (cmd.out_load) begin
      avg_rate_bps  <= (avg != '0) ? avg[RATE_FRAC_BITS +: RATE_W] : startup_rate_bps;
      window_closed <= flag_closed;
      out_of_order  <= flag_ooo;
    end
  end

endmodule

`default_nettype wire

// ----- src/ewma_source_rate_estimator_unit.sv -----
// Source rate estimator: moving average of a flow's send rate, in bits per
// second, fed by packet events.
// Input channel s_*: one item per packet event (time, time-to-go, byte count).
// Output channel m_*: exactly one result item per event, in order: the
// averaged rate and the window-closed / out-of-order flags.
// Configuration: wr_en / wr_index / wr_data, one register per write; the user
// must write only while no event is in flight, the block itself does not enforce it.
// Flow: an event that does not close a window skips the divider and the blend.
// An event that closes a window runs the 71-step restoring divider (one
// quotient bit a cycle) and, unless the average was zero, a blend on one
// shared 28x24 multiplier. One event is in work at a time: the next item is
// taken only after the last result is loaded into the output register.
// A finished result sits in the output register; a new item is accepted while
// it waits, but that item's result holds in the datapath until m_tready.
// Reset (synchronous, active high) clears the estimator to not started, drops
// m_tvalid and loads the configuration registers with their defaults.
`default_nettype none

module ewma_source_rate_estimator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: now_usec[47:0], ttg_usec[79:48], bytes_total[127:80]
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [esre_pkg::IN_DATA_W-1:0]       s_tdata,
  // m_tdata: avg_rate_bps[39:0]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [esre_pkg::OUT_DATA_W-1:0]      m_tdata,
  // m_tuser: window_closed[0], out_of_order[1]
  output logic [esre_pkg::OUT_USER_W-1:0]      m_tuser,
  input  logic                                 wr_en,
  input  logic [esre_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [esre_pkg::CFG_DATA_W-1:0]      wr_data
);
  import esre_pkg::*;

  logic [WEIGHT_W-1:0]   weight_q16;
  logic [INTERVAL_W-1:0] interval_usec;
  logic [RATE_W-1:0]     startup_rate_bps;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [RATE_W-1:0] avg_rate_bps;
  logic              window_closed;
  logic              out_of_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_q16       <= WEIGHT_RST;
      interval_usec    <= INTERVAL_RST;
      startup_rate_bps <= STARTUP_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_WEIGHT:   weight_q16       <= wr_data[WEIGHT_W-1:0];
        REG_INTERVAL: interval_usec    <= wr_data[INTERVAL_W-1:0];
        REG_STARTUP:  startup_rate_bps <= wr_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  esre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  esre_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .now_usec         (s_tdata[NOW_W-1:0]),
    .ttg_usec         (s_tdata[NOW_W +: TTG_W]),
    .bytes_total      (s_tdata[NOW_W + TTG_W +: BYTES_W]),
    .weight_q16       (weight_q16),
    .interval_usec    (interval_usec),
    .startup_rate_bps (startup_rate_bps),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .avg_rate_bps     (avg_rate_bps),
    .window_closed    (window_closed),
    .out_of_order     (out_of_order)
  );

  assign m_tdata = OUT_DATA_W'(avg_rate_bps);

  always_comb begin
    m_tuser                  = '0;
    m_tuser[USER_CLOSED_BIT] = window_closed;
    m_tuser[USER_OOO_BIT]    = out_of_order;
  end

endmodule

`default_nettype wire

// ----- src/esre_chk.sv -----
`default_nettype none

module esre_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [esre_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire logic [esre_pkg::OUT_USER_W-1:0]   m_tuser
);
  import esre_pkg::*;

  // a held result must not change under back-pressure
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an event is never flagged both out of order and window closing
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[USER_CLOSED_BIT] && m_tuser[USER_OOO_BIT]))
    else $error("closed and out-of-order flags both set");

  // one event at a time: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an event is in work");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

endmodule

bind ewma_source_rate_estimator_unit esre_chk u_esre_chk (.*);

`default_nettype wire
